### src/fqrm_pkg.sv
// shared types and constants for the handle queue with delete by value
`timescale 1ns / 1ps
`default_nettype none

package fqrm_pkg;

    localparam int DEPTH        = 16;
    localparam int HANDLE_WIDTH = 32;

    typedef enum logic [1:0] {
        MODE_ENQUEUE = 2'd0,
        MODE_DEQUEUE = 2'd1,
        MODE_DELETE  = 2'd2,
        MODE_LENGTH  = 2'd3
    } t_mode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic execute;
    } t_dp_cmd;

endpackage

`default_nettype wire

### src/fqrm_if.sv
// request and response channel interfaces of the handle queue
`timescale 1ns / 1ps
`default_nettype none

interface fqrm_req_if #(
    parameter int HANDLE_WIDTH = fqrm_pkg::HANDLE_WIDTH
);
    logic                    valid;
    logic                    ready;
    fqrm_pkg::t_mode         mode;
    logic [HANDLE_WIDTH-1:0] handle;

    modport source (output valid, output mode, output handle, input ready);
    modport sink   (input valid, input mode, input handle, output ready);
endinterface

interface fqrm_rsp_if #(
    parameter int DEPTH        = fqrm_pkg::DEPTH,
    parameter int HANDLE_WIDTH = fqrm_pkg::HANDLE_WIDTH
);
    localparam int LW = $clog2(DEPTH + 1);

    logic                    valid;
    logic                    ready;
    logic                    status;
    logic [HANDLE_WIDTH-1:0] head_handle;
    logic [LW-1:0]           length;

    modport source (output valid, output status, output head_handle, output length,
                    input ready);
    modport sink   (input valid, input status, input head_handle, input length,
                    output ready);
endinterface

`default_nettype wire

### src/fqrm_ctrl.sv
// controller state machine sequencing one transaction at a time
`timescale 1ns / 1ps
`default_nettype none

module fqrm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output fqrm_pkg::t_dp_cmd      o_cmd
);

    fqrm_pkg::t_state r_state;
    fqrm_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fqrm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = fqrm_pkg::ST_EXEC;
                end
            end
            fqrm_pkg::ST_EXEC: begin
                if (slot_free) begin
                    n_state = fqrm_pkg::ST_IDLE;
                end
            end
            default: n_state = fqrm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            fqrm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            fqrm_pkg::ST_EXEC: begin
                o_cmd.execute = slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fqrm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### src/fqrm_dp.sv
// datapath: cell array with per-cell compare and shift, count and result registers
`timescale 1ns / 1ps
`default_nettype none

module fqrm_dp #(
    parameter int DEPTH        = fqrm_pkg::DEPTH,
    parameter int HANDLE_WIDTH = fqrm_pkg::HANDLE_WIDTH,
    localparam int LW          = $clog2(DEPTH + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire fqrm_pkg::t_dp_cmd       i_cmd,
    input  wire fqrm_pkg::t_mode         i_mode,
    input  wire logic [HANDLE_WIDTH-1:0] i_handle,
    output logic                         o_status,
    output logic [HANDLE_WIDTH-1:0]      o_head_handle,
    output logic [LW-1:0]                o_length
);

    logic [HANDLE_WIDTH-1:0] r_cell [DEPTH];
    logic [LW-1:0]           r_count;
    logic [LW-1:0]           n_count;
    logic [DEPTH-1:0]        r_match;
    logic [DEPTH-1:0]        n_match;
    fqrm_pkg::t_mode         r_mode;
    logic [HANDLE_WIDTH-1:0] r_handle;
    logic                    r_out_status;
    logic [HANDLE_WIDTH-1:0] r_out_head;
    logic [LW-1:0]           r_out_len;

    logic                    handle_zero;
    logic                    is_full;
    logic                    is_empty;
    logic                    err;
    logic                    do_write;
    logic                    do_shift;
    logic [DEPTH-1:0]        pfx;
    logic [DEPTH-1:0]        shift_vec;

    // per-cell compare against the incoming handle, limited to held entries
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_match[i] = (r_cell[i] == i_handle) && (r_count > LW'(i));
        end
    end

    // cell i moves when the first match sits at or below it
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            pfx[i] = |(r_match & ({DEPTH{1'b1}} >> (DEPTH - 1 - i)));
        end
    end

    assign handle_zero = (r_handle == '0);
    assign is_full     = (r_count == LW'(DEPTH));
    assign is_empty    = (r_count == '0);

    always_comb begin
        err       = 1'b0;
        do_write  = 1'b0;
        do_shift  = 1'b0;
        shift_vec = pfx;
        unique case (r_mode)
            fqrm_pkg::MODE_ENQUEUE: begin
                err      = handle_zero || is_full;
                do_write = !err;
            end
            fqrm_pkg::MODE_DEQUEUE: begin
                err       = is_empty;
                do_shift  = !err;
                shift_vec = '1;
            end
            fqrm_pkg::MODE_DELETE: begin
                err      = handle_zero || is_empty || !(|r_match);
                do_shift = !err;
            end
            fqrm_pkg::MODE_LENGTH: begin
                err = 1'b0;
            end
            default: begin
                err = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (do_write) begin
            n_count = r_count + LW'(1);
        end else if (do_shift) begin
            n_count = r_count - LW'(1);
        end else begin
            n_count = r_count;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g < DEPTH - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_cmd.execute) begin
                    if (do_shift && shift_vec[g]) begin
                        r_cell[g] <= r_cell[g+1];
                    end else if (do_write && (r_count == LW'(g))) begin
                        r_cell[g] <= r_handle;
                    end
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_cmd.execute && do_write && (r_count == LW'(g))) begin
                    r_cell[g] <= r_handle;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_handle <= i_handle;
            r_match  <= n_match;
        end
        if (i_cmd.execute) begin
            r_out_status <= err;
            r_out_head   <= (r_mode == fqrm_pkg::MODE_DEQUEUE && !err) ? r_cell[0] : '0;
            r_out_len    <= n_count;
        end
    end

    assign o_status      = r_out_status;
    assign o_head_handle = r_out_head;
    assign o_length      = r_out_len;

endmodule

`default_nettype wire

### src/fifo_queue_with_remove_by_value_top.sv
// top level of the bounded handle queue with enqueue, dequeue, delete and length
//
// usage:
//   i_req carries one operation per transaction: mode (enqueue, dequeue,
//   delete by value, length query) and a handle. o_rsp returns exactly one
//   transaction per request: status (0 ok, 1 error), the handle removed by a
//   dequeue (zero otherwise) and the number of entries held afterwards.
//   a request is captured into the mode, handle and match registers when it
//   is accepted; the execute state then writes the response register once it
//   is free, and the response transaction completes when the receiver takes it.
//   a new request is accepted only after the previous one has executed; the
//   entry compare runs in the accept cycle and the shift/update in the execute
//   cycle, set by the controller's two-state sequence.
//   delete compares every entry in parallel and closes the gap in one shift.
//   reset clears the count and all control state; entries are not cleared.
//   a stalled receiver holds the response; one further request may be
//   accepted, and its execution waits until the response register frees.
`timescale 1ns / 1ps
`default_nettype none

module fifo_queue_with_remove_by_value_top #(
    parameter int DEPTH        = fqrm_pkg::DEPTH,
    parameter int HANDLE_WIDTH = fqrm_pkg::HANDLE_WIDTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fqrm_req_if.sink  i_req,
    fqrm_rsp_if.source o_rsp
);

    localparam int LW = $clog2(DEPTH + 1);

    fqrm_pkg::t_dp_cmd       cmd;
    logic                    in_ready;
    logic                    out_valid;
    logic                    dp_status;
    logic [HANDLE_WIDTH-1:0] dp_head;
    logic [LW-1:0]           dp_length;

    fqrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    fqrm_dp #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_req.mode),
        .i_handle      (i_req.handle),
        .o_status      (dp_status),
        .o_head_handle (dp_head),
        .o_length      (dp_length)
    );

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = out_valid;
    assign o_rsp.status      = dp_status;
    assign o_rsp.head_handle = dp_head;
    assign o_rsp.length      = dp_length;

endmodule

`default_nettype wire
